FILE: rtl/udp_ipv4_frame_builder_defines.svh
// ----------------------------------------------------------------------------
// UDP/IPv4 frame builder assertion macros
// Shared assertion forms for the frame builder RTL.
// ----------------------------------------------------------------------------
`ifndef UDP_IPV4_FRAME_BUILDER_DEFINES_SVH
`define UDP_IPV4_FRAME_BUILDER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define UFB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define UFB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ufb_pkg.sv
// ----------------------------------------------------------------------------
// UDP/IPv4 frame builder package
// Request types, register indexes, header constants and derived widths.
// ----------------------------------------------------------------------------
package ufb_pkg;

  localparam int MAX_PAYLOAD = 512;
  localparam int HDR_BYTES   = 42;
  localparam int BEAT_BYTES  = 16;

  localparam int LEN_W     = $clog2(MAX_PAYLOAD + 1);
  localparam int ADDR_W    = $clog2(MAX_PAYLOAD);
  localparam int POS_W     = $clog2(MAX_PAYLOAD + HDR_BYTES + BEAT_BYTES);
  localparam int BEAT_W    = POS_W - $clog2(BEAT_BYTES);
  localparam int SLOT_W    = $clog2(BEAT_BYTES);
  localparam int HDR_IDX_W = $clog2(HDR_BYTES);
  localparam int CNT_W     = $clog2(BEAT_BYTES + 1);

  localparam logic [15:0] ETH_TYPE_IPV4   = 16'h0800;
  localparam logic [7:0]  IP_VER_IHL      = 8'h45;
  localparam logic [7:0]  IP_TOS          = 8'h00;
  localparam logic [15:0] IP_IDENT        = 16'h1000;
  localparam logic [15:0] IP_FRAG         = 16'h0000;
  localparam logic [7:0]  IP_TTL          = 8'h80;
  localparam logic [7:0]  IP_PROTO_UDP    = 8'd17;
  localparam logic [15:0] IP_HDR_LEN      = 16'd20;
  localparam logic [15:0] UDP_HDR_LEN     = 16'd8;
  localparam logic [15:0] CSUM_ALL_ONES   = 16'hFFFF;

  localparam logic [47:0] SOURCE_MAC_RESET = 48'h0001053E2553;
  localparam logic [47:0] DEST_MAC_RESET   = 48'hFFFFFFFFFFFF;

  typedef enum logic [2:0] {
    CFG_SOURCE_IP   = 3'd0,
    CFG_DEST_IP     = 3'd1,
    CFG_SOURCE_PORT = 3'd2,
    CFG_DEST_PORT   = 3'd3,
    CFG_SOURCE_MAC  = 3'd4,
    CFG_DEST_MAC    = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       last_byte;
  } byte_req_t;

  typedef struct packed {
    logic [63:0]      beat_high;
    logic [63:0]      beat_low;
    logic [CNT_W-1:0] byte_count;
    logic             frame_end;
    logic             truncated;
  } beat_req_t;

  // Ones-complement add with end-around carry; one fold is enough for two
  // 16-bit operands.
  function automatic logic [15:0] csum_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

endpackage

FILE: rtl/udp_ipv4_frame_builder.sv
// ----------------------------------------------------------------------------
// UDP/IPv4 frame builder
// Buffers a datagram payload and emits a full Ethernet/IPv4/UDP frame with
// both checksums in 16-byte beats.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                  Payload      Moves
//  --------  -------------------------  -----------  -------------------------
//  cfg       cfg_write                  cfg_index,   one register write
//                                       cfg_data
//  byte      byte_valid / byte_ready    byte_data    one payload byte request
//  beat      beat_valid / beat_ready    beat_data    one 16-byte frame beat
//
// Payload bytes are taken one per cycle while the block collects. A byte
// request marked last starts the frame: the header checksums are summed,
// then each beat is built by fetching its 16 bytes (header bytes or
// payload-memory reads), draining the memory read and handing the beat to
// the output register. The payload memory has a single read port, so each
// beat is fetched one byte at a time.
// The output register holds a finished beat while the next one is assembled;
// a stalled beat channel holds the builder at the hand-off step.
// Reset is synchronous and resets control state and configuration; the
// payload memory needs no clearing since only bytes of the current frame
// are read.
//
`include "udp_ipv4_frame_builder_defines.svh"

module udp_ipv4_frame_builder (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [2:0]           cfg_index,
  input  logic [47:0]          cfg_data,
  input  logic                 byte_valid,
  output logic                 byte_ready,
  input  ufb_pkg::byte_req_t   byte_data,
  output logic                 beat_valid,
  input  logic                 beat_ready,
  output ufb_pkg::beat_req_t   beat_data
);

  // Collect payload, sum the headers, fill a beat, drain the memory read,
  // then hand the beat to the output register.
  typedef enum logic [2:0] {
    S_COLLECT,
    S_CSUM,
    S_FILL,
    S_FLUSH,
    S_PUSH
  } state_t;

  localparam int HDR_W = ufb_pkg::HDR_BYTES * 8;
  localparam int BEAT_BITS = ufb_pkg::BEAT_BYTES * 8;

  state_t state;

  // Configuration registers.
  logic [31:0] source_ip;
  logic [31:0] dest_ip;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [47:0] source_mac;
  logic [47:0] dest_mac;

  // Per-frame state.
  logic [ufb_pkg::LEN_W-1:0]  length;
  logic [15:0]                psum;
  logic                       overflow;
  logic [ufb_pkg::BEAT_W-1:0] emit_index;
  logic [3:0]                 step;
  logic [ufb_pkg::SLOT_W-1:0] slot;
  logic [15:0]                ip_acc;
  logic [15:0]                udp_acc;

  // Read stage and beat assembly.
  logic                 rd_valid;
  logic                 rd_mem;
  logic [7:0]           rd_byte;
  logic [BEAT_BITS-1:0] beat;

  // Payload memory.
  logic [7:0]                 mem [ufb_pkg::MAX_PAYLOAD];
  logic [7:0]                 mem_q;
  logic                       mem_we;
  logic [ufb_pkg::ADDR_W-1:0] rd_addr;

  logic                       byte_accept;
  logic                       has_room;
  logic [15:0]                byte_word;
  logic [15:0]                psum_next;
  logic [ufb_pkg::LEN_W-1:0]  length_next;

  logic [15:0]                ip_len;
  logic [15:0]                udp_len;
  logic [ufb_pkg::POS_W-1:0]  frame_len;
  logic [ufb_pkg::POS_W-1:0]  base;
  logic [ufb_pkg::POS_W-1:0]  pos;
  logic [ufb_pkg::POS_W-1:0]  remaining;
  logic                       last_beat;
  logic [ufb_pkg::CNT_W-1:0]  count;
  logic                       push;

  logic [15:0]                ip_word;
  logic [15:0]                udp_word;
  logic [15:0]                ip_csum;
  logic [15:0]                udp_csum;
  logic [HDR_W-1:0]           hdr_vec;
  logic [7:0]                 hdr_bytes [ufb_pkg::HDR_BYTES];
  logic [7:0]                 hdr_byte;
  logic                       pos_in_hdr;
  logic                       pos_in_payload;

  assign byte_ready  = (state == S_COLLECT);
  assign byte_accept = byte_valid && byte_ready;
  assign has_room    = (length < ufb_pkg::LEN_W'(ufb_pkg::MAX_PAYLOAD));
  assign mem_we      = byte_accept && has_room;

  // Even positions are the high half of a network-order word.
  assign byte_word   = length[0] ? {8'h00, byte_data.payload_byte}
                                 : {byte_data.payload_byte, 8'h00};
  assign psum_next   = has_room ? ufb_pkg::csum_add(psum, byte_word) : psum;
  assign length_next = has_room ? length + 1'b1 : length;

  assign ip_len    = 16'(length) + ufb_pkg::IP_HDR_LEN + ufb_pkg::UDP_HDR_LEN;
  assign udp_len   = 16'(length) + ufb_pkg::UDP_HDR_LEN;
  assign frame_len = ufb_pkg::POS_W'(length) + ufb_pkg::POS_W'(ufb_pkg::HDR_BYTES);

  // Checksum words, one per step for each sum.
  always_comb begin
    unique case (step)
      4'd0:    ip_word = {ufb_pkg::IP_VER_IHL, ufb_pkg::IP_TOS};
      4'd1:    ip_word = ip_len;
      4'd2:    ip_word = ufb_pkg::IP_IDENT;
      4'd3:    ip_word = {ufb_pkg::IP_TTL, ufb_pkg::IP_PROTO_UDP};
      4'd4:    ip_word = source_ip[31:16];
      4'd5:    ip_word = source_ip[15:0];
      4'd6:    ip_word = dest_ip[31:16];
      4'd7:    ip_word = dest_ip[15:0];
      default: ip_word = 16'h0000;
    endcase
  end

  always_comb begin
    unique case (step)
      4'd0:    udp_word = source_ip[31:16];
      4'd1:    udp_word = source_ip[15:0];
      4'd2:    udp_word = dest_ip[31:16];
      4'd3:    udp_word = dest_ip[15:0];
      4'd4:    udp_word = {8'h00, ufb_pkg::IP_PROTO_UDP};
      4'd5:    udp_word = udp_len;
      4'd6:    udp_word = source_port;
      4'd7:    udp_word = dest_port;
      4'd8:    udp_word = udp_len;
      default: udp_word = 16'h0000;
    endcase
  end

  // A computed UDP checksum of zero goes out as all ones.
  assign ip_csum  = ~ip_acc;
  assign udp_csum = (udp_acc == ufb_pkg::CSUM_ALL_ONES) ? ufb_pkg::CSUM_ALL_ONES : ~udp_acc;

  assign hdr_vec = {dest_mac, source_mac, ufb_pkg::ETH_TYPE_IPV4,
                    ufb_pkg::IP_VER_IHL, ufb_pkg::IP_TOS, ip_len,
                    ufb_pkg::IP_IDENT, ufb_pkg::IP_FRAG,
                    ufb_pkg::IP_TTL, ufb_pkg::IP_PROTO_UDP, ip_csum,
                    source_ip, dest_ip, source_port, dest_port, udp_len, udp_csum};

  always_comb begin
    for (int i = 0; i < ufb_pkg::HDR_BYTES; i++) begin
      hdr_bytes[i] = hdr_vec[HDR_W-1-8*i -: 8];
    end
  end

  // Frame position of the byte fetched this cycle.
  assign base           = {emit_index, {ufb_pkg::SLOT_W{1'b0}}};
  assign pos            = base + ufb_pkg::POS_W'(slot);
  assign pos_in_hdr     = (pos < ufb_pkg::POS_W'(ufb_pkg::HDR_BYTES));
  assign pos_in_payload = !pos_in_hdr && (pos < frame_len);
  assign hdr_byte       = hdr_bytes[pos[ufb_pkg::HDR_IDX_W-1:0]];
  assign rd_addr        = ufb_pkg::ADDR_W'(pos - ufb_pkg::POS_W'(ufb_pkg::HDR_BYTES));

  assign remaining = frame_len - base;
  assign last_beat = (remaining <= ufb_pkg::POS_W'(ufb_pkg::BEAT_BYTES));
  assign count     = last_beat ? ufb_pkg::CNT_W'(remaining)
                               : ufb_pkg::CNT_W'(ufb_pkg::BEAT_BYTES);
  assign push      = (state == S_PUSH) && (!beat_valid || beat_ready);

  // Payload memory: written while collecting, read while filling beats.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[length[ufb_pkg::ADDR_W-1:0]] <= byte_data.payload_byte;
    end
    mem_q <= mem[rd_addr];
  end

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      source_ip   <= '0;
      dest_ip     <= '0;
      source_port <= '0;
      dest_port   <= '0;
      source_mac  <= ufb_pkg::SOURCE_MAC_RESET;
      dest_mac    <= ufb_pkg::DEST_MAC_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ufb_pkg::CFG_SOURCE_IP:   source_ip   <= cfg_data[31:0];
        ufb_pkg::CFG_DEST_IP:     dest_ip     <= cfg_data[31:0];
        ufb_pkg::CFG_SOURCE_PORT: source_port <= cfg_data[15:0];
        ufb_pkg::CFG_DEST_PORT:   dest_port   <= cfg_data[15:0];
        ufb_pkg::CFG_SOURCE_MAC:  source_mac  <= cfg_data;
        ufb_pkg::CFG_DEST_MAC:    dest_mac    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Beat assembly: bytes come in frame order, so the beat shifts left.
  always_ff @(posedge clk) begin
    rd_mem  <= pos_in_payload;
    rd_byte <= pos_in_hdr ? hdr_byte : 8'h00;
    if (rd_valid) begin
      beat <= {beat[BEAT_BITS-9:0], rd_mem ? mem_q : rd_byte};
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_COLLECT;
      length     <= '0;
      psum       <= '0;
      overflow   <= 1'b0;
      emit_index <= '0;
      step       <= '0;
      slot       <= '0;
      ip_acc     <= '0;
      udp_acc    <= '0;
      rd_valid   <= 1'b0;
      beat_valid <= 1'b0;
    end else begin
      rd_valid <= (state == S_FILL);
      if (beat_valid && beat_ready && !push) begin
        beat_valid <= 1'b0;
      end
      unique case (state)
        S_COLLECT: begin
          if (byte_accept) begin
            length   <= length_next;
            psum     <= psum_next;
            overflow <= overflow || !has_room;
            if (byte_data.last_byte) begin
              ip_acc  <= '0;
              udp_acc <= psum_next;
              step    <= '0;
              state   <= S_CSUM;
            end
          end
        end
        S_CSUM: begin
          if (step < 4'd8) begin
            ip_acc <= ufb_pkg::csum_add(ip_acc, ip_word);
          end
          udp_acc <= ufb_pkg::csum_add(udp_acc, udp_word);
          step    <= step + 1'b1;
          if (step == 4'd8) begin
            emit_index <= '0;
            slot       <= '0;
            state      <= S_FILL;
          end
        end
        S_FILL: begin
          slot <= slot + 1'b1;
          if (slot == ufb_pkg::SLOT_W'(ufb_pkg::BEAT_BYTES - 1)) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          state <= S_PUSH;
        end
        S_PUSH: begin
          if (push) begin
            beat_valid           <= 1'b1;
            beat_data.beat_high  <= beat[BEAT_BITS-1:64];
            beat_data.beat_low   <= beat[63:0];
            beat_data.byte_count <= count;
            beat_data.frame_end  <= last_beat;
            beat_data.truncated  <= overflow;
            if (last_beat) begin
              length     <= '0;
              psum       <= '0;
              overflow   <= 1'b0;
              emit_index <= '0;
              state      <= S_COLLECT;
            end else begin
              emit_index <= emit_index + 1'b1;
              slot       <= '0;
              state      <= S_FILL;
            end
          end
        end
        default: state <= S_COLLECT;
      endcase
    end
  end

  `UFB_ASSERT_NEXT(a_frame_end_clears, push && last_beat, (state == S_COLLECT) && (length == '0) && !overflow, "frame state not cleared after the last beat")
  `UFB_ASSERT_SAME(a_beat_count_range, beat_valid, (beat_data.byte_count != '0) && (beat_data.byte_count <= ufb_pkg::CNT_W'(ufb_pkg::BEAT_BYTES)), "beat byte count out of range")
  `UFB_ASSERT_SAME(a_length_bound, 1'b1, length <= ufb_pkg::LEN_W'(ufb_pkg::MAX_PAYLOAD), "payload length past capacity")
  `UFB_ASSERT_SAME(a_read_stage_window, rd_valid, (state == S_FILL) || (state == S_FLUSH), "beat read data outside a fill")
  `UFB_ASSERT_NEXT(a_push_hands_off, push, beat_valid, "beat lost at the output register")

endmodule
